### design/sdi_pkg.sv
package sdi_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRE     = 3'd1,
    PH_DESEL   = 3'd2,
    PH_READY   = 3'd3,
    PH_SELFAIL = 3'd4,
    PH_FRAME   = 3'd5,
    PH_RESP    = 3'd6,
    PH_OCR     = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RESET_TRIES    = 3'd0,
    CFG_OP_COND_TRIES  = 3'd1,
    CFG_READY_POLLS    = 3'd2,
    CFG_RESPONSE_POLLS = 3'd3,
    CFG_BLOCK_LENGTH   = 3'd4
  } cfg_idx_e;

  localparam logic [5:0]  CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0]  CMD_SEND_OP  = 6'd1;
  localparam logic [5:0]  CMD_IF_COND  = 6'd8;
  localparam logic [5:0]  CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0]  CMD_APP_OP   = 6'd41;
  localparam logic [5:0]  CMD_APP      = 6'd55;
  localparam logic [5:0]  CMD_READ_OCR = 6'd58;
  localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
  localparam logic [31:0] HCS_BIT      = 32'h4000_0000;
  localparam logic [15:0] IDLE_BYTES   = 16'd10;
  localparam logic [2:0]  KIND_NONE    = 3'd0;
  localparam logic [2:0]  KIND_MMC     = 3'd1;
  localparam logic [2:0]  KIND_SD1     = 3'd2;
  localparam logic [2:0]  KIND_SD2     = 3'd3;
  localparam logic [2:0]  KIND_SD2HC   = 3'd4;

  typedef struct packed {
    logic       begin_req;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       select_low;
    logic       busy_res;
    logic       done_res;
    logic [2:0] card_kind;
    logic       failed;
    logic       fast_clock;
  } out_t;

  typedef struct packed {
    logic [7:0]  reset_tries;
    logic [15:0] op_cond_tries;
    logic [15:0] ready_polls;
    logic [7:0]  response_polls;
    logic [12:0] block_length;
  } cfg_t;

  function automatic logic [7:0] frame_byte(logic [2:0] k, logic app,
                                            logic [5:0] idx, logic [31:0] arg);
    logic [5:0]  cmd;
    logic [31:0] a;
    logic [7:0]  r;
    cmd = app ? CMD_APP : idx;
    a   = app ? 32'd0 : arg;
    unique case (k)
      3'd0: r = {2'b01, cmd};
      3'd1: r = a[31:24];
      3'd2: r = a[23:16];
      3'd3: r = a[15:8];
      3'd4: r = a[7:0];
      default: begin
        if (cmd == CMD_GO_IDLE) r = 8'h95;
        else if (cmd == CMD_IF_COND) r = 8'h87;
        else r = 8'h01;
      end
    endcase
    return r;
  endfunction

endpackage

### design/sdi_cfg_regs.sv
module sdi_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output sdi_pkg::cfg_t     cfg_o
);
  sdi_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_tries    <= 8'd21;
      cfg_q.op_cond_tries  <= 16'd1001;
      cfg_q.ready_polls    <= 16'd65535;
      cfg_q.response_polls <= 8'd11;
      cfg_q.block_length   <= 13'd512;
    end else if (cfg_we_i) begin
      unique case (sdi_pkg::cfg_idx_e'(cfg_idx_i))
        sdi_pkg::CFG_RESET_TRIES:    cfg_q.reset_tries    <= cfg_data_i[7:0];
        sdi_pkg::CFG_OP_COND_TRIES:  cfg_q.op_cond_tries  <= cfg_data_i;
        sdi_pkg::CFG_READY_POLLS:    cfg_q.ready_polls    <= cfg_data_i;
        sdi_pkg::CFG_RESPONSE_POLLS: cfg_q.response_polls <= cfg_data_i[7:0];
        sdi_pkg::CFG_BLOCK_LENGTH:   cfg_q.block_length   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

### design/sdi_seq_core.sv
module sdi_seq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sdi_pkg::in_t      item_i,
  input  sdi_pkg::cfg_t     cfg_i,
  output sdi_pkg::out_t     res_o
);
  sdi_pkg::phase_e phase_q, phase_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] arg_q, arg_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [15:0] try_q, try_d, poll_q, poll_d;
  logic [7:0]  ocr0_q, ocr0_d, ocr2_q, ocr2_d;
  logic [2:0]  kind_q, kind_d;
  logic        app_q, app_d;
  logic [7:0]  tx, rx, res;
  logic        sel, ending, busy, do_reply, v2;

  always_comb begin
    phase_d = phase_q; idx_d = idx_q; arg_d = arg_q; fcnt_d = fcnt_q;
    try_d = try_q; poll_d = poll_q; ocr0_d = ocr0_q; ocr2_d = ocr2_q;
    kind_d = kind_q; app_d = app_q;
    tx = 8'hFF; sel = 1'b0; ending = 1'b0; do_reply = 1'b0;
    rx = item_i.rx_byte; res = rx; v2 = 1'b0;
    unique case (phase_q)
      sdi_pkg::PH_IDLE: begin
        if (item_i.begin_req) begin
          kind_d = sdi_pkg::KIND_NONE; poll_d = 16'd1; phase_d = sdi_pkg::PH_PRE;
        end
      end
      sdi_pkg::PH_PRE: begin
        if (poll_q < sdi_pkg::IDLE_BYTES) poll_d = poll_q + 16'd1;
        else begin
          try_d = 16'd1; idx_d = sdi_pkg::CMD_GO_IDLE; arg_d = '0; app_d = 1'b0;
          phase_d = sdi_pkg::PH_DESEL;
        end
      end
      sdi_pkg::PH_DESEL: begin
        poll_d = 16'd1; phase_d = sdi_pkg::PH_READY; sel = 1'b1;
      end
      sdi_pkg::PH_READY: begin
        sel = 1'b1;
        if (rx == 8'hFF) begin
          fcnt_d = 3'd0; phase_d = sdi_pkg::PH_FRAME;
          tx = sdi_pkg::frame_byte(3'd0, app_q, idx_q, arg_q);
        end else if (poll_q >= cfg_i.ready_polls) begin
          phase_d = sdi_pkg::PH_SELFAIL; sel = 1'b0;
        end else poll_d = poll_q + 16'd1;
      end
      sdi_pkg::PH_SELFAIL: begin
        do_reply = 1'b1; res = 8'hFF;
      end
      sdi_pkg::PH_FRAME: begin
        sel = 1'b1;
        if (fcnt_q < 3'd5) begin
          fcnt_d = fcnt_q + 3'd1;
          tx = sdi_pkg::frame_byte(fcnt_d, app_q, idx_q, arg_q);
        end else begin
          poll_d = 16'd1; phase_d = sdi_pkg::PH_RESP;
        end
      end
      sdi_pkg::PH_RESP: begin
        if (!rx[7] || poll_q >= {8'd0, cfg_i.response_polls}) do_reply = 1'b1;
        else begin
          poll_d = poll_q + 16'd1; sel = 1'b1;
        end
      end
      sdi_pkg::PH_OCR: begin
        sel = 1'b1;
        unique case (fcnt_q[1:0])
          2'd0: ocr0_d = rx;
          2'd2: ocr2_d = rx;
          default: ;
        endcase
        if (fcnt_q < 3'd3) fcnt_d = fcnt_q + 3'd1;
        else if (idx_q == sdi_pkg::CMD_IF_COND) begin
          if (ocr2_q == 8'h01 && rx == 8'hAA) begin
            try_d = 16'd1; idx_d = sdi_pkg::CMD_APP_OP; arg_d = sdi_pkg::HCS_BIT;
            app_d = 1'b1; phase_d = sdi_pkg::PH_DESEL; sel = 1'b0;
          end else begin
            phase_d = sdi_pkg::PH_IDLE; ending = 1'b1; sel = 1'b0;
          end
        end else begin
          kind_d = ocr0_q[6] ? sdi_pkg::KIND_SD2HC : sdi_pkg::KIND_SD2;
          phase_d = sdi_pkg::PH_IDLE; ending = 1'b1; sel = 1'b0;
        end
      end
      default: ;
    endcase

    // command reply handling; new command goes out through a deselect byte
    if (do_reply) begin
      sel = 1'b0;
      phase_d = sdi_pkg::PH_DESEL;
      if (app_q && res <= 8'd1) begin
        app_d = 1'b0;
      end else begin
        app_d = 1'b0;
        priority case (1'b1)
          idx_q == sdi_pkg::CMD_GO_IDLE: begin
            if (res == 8'd1) begin
              idx_d = sdi_pkg::CMD_IF_COND; arg_d = sdi_pkg::ARG_IF_COND;
            end else if (try_q >= {8'd0, cfg_i.reset_tries}) begin
              phase_d = sdi_pkg::PH_IDLE; ending = 1'b1;
            end else begin
              try_d = try_q + 16'd1; arg_d = '0;
            end
          end
          idx_q == sdi_pkg::CMD_IF_COND: begin
            if (res == 8'd1) begin
              fcnt_d = 3'd0; phase_d = sdi_pkg::PH_OCR; sel = 1'b1;
            end else begin
              idx_d = sdi_pkg::CMD_APP_OP; arg_d = '0; app_d = 1'b1;
            end
          end
          idx_q == sdi_pkg::CMD_APP_OP && !arg_q[30] && kind_q == sdi_pkg::KIND_NONE:
          begin
            try_d = 16'd1;
            if (res <= 8'd1) begin
              kind_d = sdi_pkg::KIND_SD1; app_d = 1'b1;
            end else begin
              kind_d = sdi_pkg::KIND_MMC; idx_d = sdi_pkg::CMD_SEND_OP; arg_d = '0;
            end
          end
          idx_q == sdi_pkg::CMD_APP_OP || idx_q == sdi_pkg::CMD_SEND_OP: begin
            v2 = (idx_q == sdi_pkg::CMD_APP_OP) && arg_q[30];
            if (res == 8'd0) begin
              idx_d = v2 ? sdi_pkg::CMD_READ_OCR : sdi_pkg::CMD_BLOCKLEN;
              arg_d = v2 ? 32'd0 : {19'd0, cfg_i.block_length};
            end else if (try_q >= cfg_i.op_cond_tries) begin
              kind_d = sdi_pkg::KIND_NONE; phase_d = sdi_pkg::PH_IDLE; ending = 1'b1;
            end else begin
              try_d = try_q + 16'd1;
              app_d = (idx_q == sdi_pkg::CMD_APP_OP);
            end
          end
          idx_q == sdi_pkg::CMD_READ_OCR: begin
            if (res == 8'd0) begin
              fcnt_d = 3'd0; phase_d = sdi_pkg::PH_OCR; sel = 1'b1;
            end else begin
              phase_d = sdi_pkg::PH_IDLE; ending = 1'b1;
            end
          end
          idx_q == sdi_pkg::CMD_BLOCKLEN: begin
            if (res != 8'd0) kind_d = sdi_pkg::KIND_NONE;
            phase_d = sdi_pkg::PH_IDLE; ending = 1'b1;
          end
          default: begin
            kind_d = sdi_pkg::KIND_NONE; phase_d = sdi_pkg::PH_IDLE; ending = 1'b1;
          end
        endcase
      end
    end
    busy = (phase_d != sdi_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdi_pkg::PH_IDLE; idx_q <= '0; arg_q <= '0; fcnt_q <= '0;
      try_q <= '0; poll_q <= '0; ocr0_q <= '0; ocr2_q <= '0;
      kind_q <= '0; app_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; idx_q <= idx_d; arg_q <= arg_d; fcnt_q <= fcnt_d;
      try_q <= try_d; poll_q <= poll_d; ocr0_q <= ocr0_d; ocr2_q <= ocr2_d;
      kind_q <= kind_d; app_q <= app_d;
    end
  end

  always_comb begin
    res_o.tx_byte    = tx;
    res_o.select_low = sel;
    res_o.busy_res   = busy;
    res_o.done_res   = ending;
    res_o.card_kind  = kind_d;
    res_o.failed     = ending && (kind_d == sdi_pkg::KIND_NONE);
    res_o.fast_clock = !busy && (kind_d != sdi_pkg::KIND_NONE);
  end
endmodule

### design/sdi_out_reg.sv
module sdi_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sdi_pkg::out_t  res_i,
  input  logic           out_stall_i,
  output logic           full_o,
  output logic           out_valid_o,
  output sdi_pkg::out_t  out_data_o
);
  logic          valid_q;
  sdi_pkg::out_t data_q;

  assign full_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (load_i) valid_q <= 1'b1;
    else if (!out_stall_i) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
endmodule

### design/sd_spi_init_sequencer_top.sv
// Channel | direction | handshake             | payload
// input   | in        | in_valid_i/in_stall_o  | sdi_pkg::in_t
// output  | out       | out_valid_o/out_stall_i| sdi_pkg::out_t
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
// One transaction per cycle while the output is not stalled; each accepted input gives one result in the next cycle.
// The sequencer state update and the output register form the only stage.
// Input stalls only while the output register holds a result that is stalled.
// Reset (async, active low) leaves the sequencer idle with default limits.
module sd_spi_init_sequencer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sdi_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sdi_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  sdi_pkg::cfg_t cfg;
  sdi_pkg::out_t res;
  logic          full, step;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  sdi_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  sdi_seq_core u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_data_i), .cfg_i(cfg), .res_o(res)
  );

  sdi_out_reg u_out (
    .clk_i, .rst_ni, .load_i(step), .res_i(res), .out_stall_i,
    .full_o(full), .out_valid_o, .out_data_o
  );
endmodule

### design/sdi_checker.sv
module sdi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sdi_pkg::out_t out_data_o
);
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("bad stall");
  a_accept_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o) else $error("lost result");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res && !out_data_o.select_low)
    else $error("bad done");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> $stable(out_data_o)) else $error("payload moved");
endmodule

bind sd_spi_init_sequencer_top sdi_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
